// File: src/okt_pkg.sv
// package for the ordered keyed entry table
// shared defaults, command and status codes, compare result type; no dependencies
package okt_pkg;

  localparam int EntriesDef  = 16;
  localparam int KeyBytesDef = 32;

  // command modes
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  // outputs of the shared compare unit
  typedef struct packed {
    logic byte_eq;
    logic code_eq;
  } cmp_t;

endpackage

// File: src/okt_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module okt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/okt_match.sv
// shared compare unit: one key byte and one code per cycle
// depends on okt_pkg
module okt_match (
  input  logic [7:0]    stored_byte_i,
  input  logic [7:0]    key_byte_i,
  input  logic [31:0]   stored_code_i,
  input  logic [31:0]   cmd_code_i,
  output okt_pkg::cmp_t cmp_o
);

  // equality of the byte pair and the code pair
  always_comb begin
    cmp_o.byte_eq = (stored_byte_i == key_byte_i);
    cmp_o.code_eq = (stored_code_i == cmd_code_i);
  end

endmodule

// File: src/ordered_keyed_entry_table_unit.sv
// top level of the ordered keyed entry table
// depends on okt_pkg, okt_ram, okt_match

// Keeps up to ENTRIES entries (key text plus 32-bit code) in insertion order,
// compacted so the oldest is always slot 0. A key arrives one byte per item on
// start_i while busy_o is low; a nonzero byte is collected and gives no result.
// The zero byte runs the command and result_valid_o pulses for exactly one cycle
// when it finishes; the receiver cannot stall it. Query goes straight to the
// result; add copies the key into the new slot byte by byte, then writes its
// length and code; remove reads each held entry, compares it in the shared
// compare unit, and copies a survivor's text down byte by byte. Text moves
// through the text ram one byte at a time. Mode 3 clears the key and gives no result.
module ordered_keyed_entry_table_unit #(
  parameter int ENTRIES   = okt_pkg::EntriesDef,
  parameter int KEY_BYTES = okt_pkg::KeyBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         mode_i,
  input  logic [7:0]         key_byte_i,
  input  logic signed [31:0] entry_code_i,
  input  logic               match_any_text_i,
  input  logic               match_any_code_i,
  output logic               busy_o,
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic [4:0]         removed_count_o,
  output logic [4:0]         entry_count_o,
  output logic signed [31:0] head_code_o,
  output logic               head_valid_o
);

  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int IW  = $clog2(ENTRIES);
  localparam int KLW = $clog2(KEY_BYTES + 1);
  localparam int KIW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int TD  = ENTRIES * KEY_BYTES;
  localparam int TAW = $clog2(TD);
  localparam int MW  = KLW + 32;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_RD, S_ADD_WR, S_ADD_META, S_META_RD, S_META,
    S_TXT_RD, S_TXT_CMP, S_DECIDE, S_CP_RD, S_CP_WR, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0]  held_q, held_d, idx_q, idx_d, keep_q, keep_d, rem_q, rem_d;
  logic [KLW-1:0] klen_q, klen_d, j_q, j_d, len_q, len_d;
  logic           kovf_q, kovf_d, tm_q, tm_d, ce_q, ce_d;
  logic [31:0]    head_q, head_d, code_q, code_d, mcode_q, mcode_d;
  logic           anyt_q, anyt_d, anyc_q, anyc_d;
  logic [1:0]     st_q, st_d;
  logic           rv_q, rv_d;
  logic [1:0]     ost_q;
  logic [4:0]     orem_q, ocnt_q;
  logic [31:0]    ohead_q;
  logic           ohv_q;

  // ram control
  logic           key_we, txt_we, meta_we;
  logic [KIW-1:0] key_waddr, key_raddr;
  logic [7:0]     key_rdata, txt_wdata, txt_rdata;
  logic [TAW-1:0] txt_waddr, txt_raddr;
  logic [IW-1:0]  meta_waddr, meta_raddr;
  logic [MW-1:0]  meta_wdata, meta_rdata;
  okt_pkg::cmp_t  cmp;

  logic [KLW-1:0] j_inc;
  logic [CW-1:0]  idx_inc, keep_inc;
  logic           accept;

  assign accept   = start_i && (state_q == S_IDLE);
  assign j_inc    = KLW'(j_q + 1'b1);
  assign idx_inc  = CW'(idx_q + 1'b1);
  assign keep_inc = CW'(keep_q + 1'b1);

  okt_ram #(.WIDTH(8), .DEPTH(KEY_BYTES)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(key_waddr), .wdata_i(key_byte_i),
    .raddr_i(key_raddr), .rdata_o(key_rdata)
  );

  okt_ram #(.WIDTH(8), .DEPTH(TD)) u_text_ram (
    .clk_i, .we_i(txt_we), .waddr_i(txt_waddr), .wdata_i(txt_wdata),
    .raddr_i(txt_raddr), .rdata_o(txt_rdata)
  );

  okt_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_meta_ram (
    .clk_i, .we_i(meta_we), .waddr_i(meta_waddr), .wdata_i(meta_wdata),
    .raddr_i(meta_raddr), .rdata_o(meta_rdata)
  );

  okt_match u_match (
    .stored_byte_i(txt_rdata), .key_byte_i(key_rdata),
    .stored_code_i(meta_rdata[31:0]), .cmd_code_i(code_q), .cmp_o(cmp)
  );

  // fixed ram addressing
  assign key_waddr  = klen_q[KIW-1:0];
  assign key_raddr  = j_q[KIW-1:0];
  assign meta_raddr = idx_q[IW-1:0];
  assign txt_raddr  = TAW'(int'(idx_q[IW-1:0]) * KEY_BYTES + int'(j_q));

  // sequencer next state
  always_comb begin
    state_d = state_q;
    held_d  = held_q;  idx_d  = idx_q;  keep_d = keep_q; rem_d = rem_q;
    klen_d  = klen_q;  j_d    = j_q;    len_d  = len_q;
    kovf_d  = kovf_q;  tm_d   = tm_q;   ce_d   = ce_q;
    head_d  = head_q;  code_d = code_q; mcode_d = mcode_q;
    anyt_d  = anyt_q;  anyc_d = anyc_q; st_d   = st_q;
    rv_d    = 1'b0;
    key_we  = 1'b0;
    txt_we  = 1'b0;
    meta_we = 1'b0;
    txt_waddr  = TAW'(int'(held_q[IW-1:0]) * KEY_BYTES + int'(j_q));
    txt_wdata  = key_rdata;
    meta_waddr = held_q[IW-1:0];
    meta_wdata = {klen_q, code_q};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          code_d = entry_code_i;
          anyt_d = match_any_text_i;
          anyc_d = match_any_code_i;
          j_d    = '0;
          rem_d  = '0;
          if (key_byte_i != 8'd0) begin
            // collect one key byte
            if (klen_q < KLW'(KEY_BYTES)) begin
              key_we = 1'b1;
              klen_d = KLW'(klen_q + 1'b1);
            end else begin
              kovf_d = 1'b1;
            end
          end else begin
            unique case (mode_i)
              okt_pkg::MODE_ADD: begin
                if (held_q >= CW'(ENTRIES)) begin
                  st_d    = okt_pkg::ST_FULL;
                  state_d = S_DONE;
                end else begin
                  st_d    = okt_pkg::ST_ADDED;
                  state_d = (klen_q == '0) ? S_ADD_META : S_ADD_RD;
                end
              end
              okt_pkg::MODE_REMOVE: begin
                st_d    = okt_pkg::ST_DONE;
                idx_d   = '0;
                keep_d  = '0;
                state_d = S_META_RD;
              end
              okt_pkg::MODE_QUERY: begin
                st_d    = okt_pkg::ST_DONE;
                state_d = S_DONE;
              end
              default: begin
                klen_d = '0;
                kovf_d = 1'b0;
              end
            endcase
          end
        end
      end
      S_ADD_RD: state_d = S_ADD_WR;
      S_ADD_WR: begin
        // key byte into the new slot
        txt_we = 1'b1;
        j_d    = j_inc;
        state_d = (j_inc == klen_q) ? S_ADD_META : S_ADD_RD;
      end
      S_ADD_META: begin
        meta_we = 1'b1;
        if (held_q == '0) head_d = code_q;
        held_d  = CW'(held_q + 1'b1);
        state_d = S_DONE;
      end
      S_META_RD: begin
        if (idx_q == held_q) begin
          held_d  = keep_q;
          state_d = S_DONE;
        end else begin
          state_d = S_META;
        end
      end
      S_META: begin
        // length and code of the entry under test
        len_d   = meta_rdata[MW-1:32];
        mcode_d = meta_rdata[31:0];
        ce_d    = anyc_q || cmp.code_eq;
        j_d     = '0;
        state_d = S_DECIDE;
        if (anyt_q) begin
          tm_d = 1'b1;
        end else if (kovf_q || (meta_rdata[MW-1:32] != klen_q)) begin
          tm_d = 1'b0;
        end else if (klen_q == '0) begin
          tm_d = 1'b1;
        end else begin
          state_d = S_TXT_RD;
        end
      end
      S_TXT_RD: state_d = S_TXT_CMP;
      S_TXT_CMP: begin
        if (!cmp.byte_eq) begin
          tm_d    = 1'b0;
          state_d = S_DECIDE;
        end else if (j_inc == len_q) begin
          tm_d    = 1'b1;
          state_d = S_DECIDE;
        end else begin
          j_d     = j_inc;
          state_d = S_TXT_RD;
        end
      end
      S_DECIDE: begin
        j_d     = '0;
        state_d = S_META_RD;
        if (tm_q && ce_q) begin
          rem_d = CW'(rem_q + 1'b1);
          idx_d = idx_inc;
        end else begin
          if (keep_q == '0) head_d = mcode_q;
          if (keep_q == idx_q || len_q == '0) begin
            meta_we    = (keep_q != idx_q);
            meta_waddr = keep_q[IW-1:0];
            meta_wdata = {len_q, mcode_q};
            keep_d     = keep_inc;
            idx_d      = idx_inc;
          end else begin
            // survivor moves down: meta now, text bytes after
            meta_we    = 1'b1;
            meta_waddr = keep_q[IW-1:0];
            meta_wdata = {len_q, mcode_q};
            state_d    = S_CP_RD;
          end
        end
      end
      S_CP_RD: state_d = S_CP_WR;
      S_CP_WR: begin
        txt_we    = 1'b1;
        txt_waddr = TAW'(int'(keep_q[IW-1:0]) * KEY_BYTES + int'(j_q));
        txt_wdata = txt_rdata;
        if (j_inc == len_q) begin
          keep_d  = keep_inc;
          idx_d   = idx_inc;
          j_d     = '0;
          state_d = S_META_RD;
        end else begin
          j_d     = j_inc;
          state_d = S_CP_RD;
        end
      end
      S_DONE: begin
        rv_d    = 1'b1;
        klen_d  = '0;
        kovf_d  = 1'b0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      held_q  <= '0;
      klen_q  <= '0;
      kovf_q  <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      klen_q  <= klen_d;
      kovf_q  <= kovf_d;
      rv_q    <= rv_d;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;  keep_q <= keep_d; rem_q <= rem_d;
    j_q   <= j_d;    len_q  <= len_d;  tm_q  <= tm_d;  ce_q <= ce_d;
    head_q <= head_d; code_q <= code_d; mcode_q <= mcode_d;
    anyt_q <= anyt_d; anyc_q <= anyc_d; st_q <= st_d;
    if (state_q == S_DONE) begin
      ost_q   <= st_q;
      orem_q  <= 5'(rem_q);
      ocnt_q  <= 5'(held_q);
      ohv_q   <= (held_q != '0);
      ohead_q <= (held_q != '0) ? head_q : 32'd0;
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign result_valid_o  = rv_q;
  assign status_o        = ost_q;
  assign removed_count_o = orem_q;
  assign entry_count_o   = ocnt_q;
  assign head_code_o     = ohead_q;
  assign head_valid_o    = ohv_q;

  // checks
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(ENTRIES)) else $error("held count beyond pool size");
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o) else $error("result while busy");
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (head_valid_o == (held_q != '0)))
    else $error("head valid disagrees with count");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == okt_pkg::ST_FULL) |-> (held_q == CW'(ENTRIES)))
    else $error("full status with room left");

endmodule

// File: dv/testbench.sv
// self-checking testbench for ordered_keyed_entry_table_unit
// depends on okt_pkg and the block's rtl; predicts every result and checks it in order
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Entries  = okt_pkg::EntriesDef;
  localparam int KeyBytes = okt_pkg::KeyBytesDef;
  localparam int WatchdogLimit = 40000;
  localparam int DrainCycles = 200;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         removed_count;
    logic [4:0]         entry_count;
    logic signed [31:0] head_code;
    logic               head_valid;
  } table_result_t;

  // table predictor plus queue of expected results
  class table_scoreboard;
    logic [7:0]  text_q [Entries][KeyBytes];
    int          len_q [Entries];
    logic [31:0] code_q [Entries];
    int          held;
    logic [7:0]  key_buf [KeyBytes];
    int          key_len;
    bit          key_ovf;
    table_result_t pending_q [$];
    int          errors;

    function new();
      held = 0;
      key_len = 0;
      key_ovf = 0;
      errors = 0;
    endfunction

    function bit text_hit(int slot);
      bit hit;
      hit = !key_ovf && (len_q[slot] == key_len);
      for (int j = 0; j < KeyBytes; j++)
        if (hit && j < key_len && text_q[slot][j] != key_buf[j]) hit = 0;
      return hit;
    endfunction

    // note one accepted item and predict its result
    function void note_item(logic [1:0] mode, logic [7:0] kb, logic [31:0] code,
                            bit any_t, bit any_c);
      table_result_t r;
      int keep;
      bit t, c;
      if (kb != 0) begin
        if (key_len < KeyBytes) begin
          key_buf[key_len] = kb;
          key_len++;
        end else key_ovf = 1;
        return;
      end
      r = '0;
      r.status = okt_pkg::ST_DONE;
      if (mode == okt_pkg::MODE_ADD) begin
        if (held >= Entries) r.status = okt_pkg::ST_FULL;
        else begin
          for (int j = 0; j < KeyBytes; j++) text_q[held][j] = key_buf[j];
          len_q[held] = key_len;
          code_q[held] = code;
          held++;
          r.status = okt_pkg::ST_ADDED;
        end
      end else if (mode == okt_pkg::MODE_REMOVE) begin
        keep = 0;
        for (int i = 0; i < held; i++) begin
          t = any_t || text_hit(i);
          c = any_c || code_q[i] == code;
          if (t && c) r.removed_count++;
          else begin
            text_q[keep] = text_q[i];
            len_q[keep] = len_q[i];
            code_q[keep] = code_q[i];
            keep++;
          end
        end
        held = keep;
      end
      key_len = 0;
      key_ovf = 0;
      if (mode == okt_pkg::MODE_NONE) return;
      r.entry_count = held[4:0];
      r.head_valid = held > 0;
      r.head_code = held > 0 ? code_q[0] : 0;
      pending_q.push_back(r);
    endfunction

    // compare one result with the oldest prediction
    function void check_result(table_result_t act);
      table_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result %p", act);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (act.status !== e.status) begin
        $error("status exp %0d act %0d", e.status, act.status); errors++;
      end
      if (act.removed_count !== e.removed_count) begin
        $error("removed_count exp %0d act %0d", e.removed_count, act.removed_count);
        errors++;
      end
      if (act.entry_count !== e.entry_count) begin
        $error("entry_count exp %0d act %0d", e.entry_count, act.entry_count); errors++;
      end
      if (act.head_code !== e.head_code) begin
        $error("head_code exp %0d act %0d", e.head_code, act.head_code); errors++;
      end
      if (act.head_valid !== e.head_valid) begin
        $error("head_valid exp %0d act %0d", e.head_valid, act.head_valid); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic start_i = 0;
  logic [1:0] mode_i = okt_pkg::MODE_QUERY;
  logic [7:0] key_byte_i = 0;
  logic signed [31:0] entry_code_i = 0;
  logic match_any_text_i = 0, match_any_code_i = 0;
  logic busy_o, result_valid_o, head_valid_o;
  logic [1:0] status_o;
  logic [4:0] removed_count_o, entry_count_o;
  logic signed [31:0] head_code_o;

  table_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;
  logic [7:0] key_pool [4][8];
  logic [31:0] code_pool [4];

  ordered_keyed_entry_table_unit DUT (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  // result capture and watchdog
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      sb.check_result({status_o, removed_count_o, entry_count_o, head_code_o, head_valid_o});
    if (rst_ni && ((start_i && !busy_o) || result_valid_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // offer one item and hold it until accepted, with random bursts and gaps
  task automatic send_item(logic [1:0] mode, logic [7:0] kb, logic [31:0] code,
                           bit any_t, bit any_c);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        start_i <= 0;
        mode_i <= 2'($urandom);
        key_byte_i <= 8'($urandom);
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    start_i <= 1;
    mode_i <= mode;
    key_byte_i <= kb;
    entry_code_i <= code;
    match_any_text_i <= any_t;
    match_any_code_i <= any_c;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(mode, kb, code, any_t, any_c);
  endtask

  // key bytes then the zero byte that runs the command
  task automatic send_cmd(logic [1:0] mode, int len, int pool, logic [31:0] code,
                          bit any_t, bit any_c);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (pool >= 0 && i < 8) ? key_pool[pool][i] : 8'($urandom_range(1, 255));
      send_item(2'($urandom), b, $urandom, 1'($urandom), 1'($urandom));
    end
    send_item(mode, 8'd0, code, any_t, any_c);
  endtask

  task automatic wait_drain();
    start_i <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int len, pool, r;
    logic [1:0] m;
    for (int p = 0; p < 4; p++) begin
      code_pool[p] = $urandom;
      for (int i = 0; i < 8; i++) key_pool[p][i] = 8'($urandom_range(1, 255));
    end
    key_pool[0][0] = 8'hff;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty table, extremes, overflow, full pool, wildcards, mode 3
    send_cmd(okt_pkg::MODE_QUERY, 0, -1, 0, 0, 0);
    send_cmd(okt_pkg::MODE_REMOVE, 0, -1, 0, 0, 0);
    send_cmd(okt_pkg::MODE_ADD, 0, -1, 32'h8000_0000, 0, 0);
    send_cmd(okt_pkg::MODE_ADD, KeyBytes + 3, -1, 32'h7fff_ffff, 0, 0);
    send_cmd(okt_pkg::MODE_ADD, KeyBytes, -1, 32'hffff_ffff, 0, 0);
    send_cmd(okt_pkg::MODE_REMOVE, KeyBytes + 3, -1, 32'h7fff_ffff, 0, 0);
    send_cmd(okt_pkg::MODE_NONE, 3, 0, 0, 0, 0);
    send_cmd(okt_pkg::MODE_REMOVE, 0, -1, 32'h8000_0000, 0, 0);
    for (int i = 0; i < Entries + 1; i++) send_cmd(okt_pkg::MODE_ADD, 1, 1, i, 0, 0);
    send_cmd(okt_pkg::MODE_QUERY, 0, -1, 0, 0, 0);
    send_cmd(okt_pkg::MODE_REMOVE, 1, 1, 5, 0, 0);
    send_cmd(okt_pkg::MODE_REMOVE, 0, -1, 7, 1, 0);
    send_cmd(okt_pkg::MODE_REMOVE, 1, 1, 0, 0, 1);
    send_cmd(okt_pkg::MODE_REMOVE, 0, -1, 0, 1, 1);
    wait_drain();

    // random commands drawn from a small key and code pool so removes hit
    for (int n = 0; n < 360; n++) begin
      r = $urandom_range(0, 99);
      m = r < 55 ? okt_pkg::MODE_ADD : r < 80 ? okt_pkg::MODE_REMOVE :
          r < 95 ? okt_pkg::MODE_QUERY : okt_pkg::MODE_NONE;
      pool = $urandom_range(0, 4) == 0 ? -1 : $urandom_range(0, 3);
      len = $urandom_range(0, 9) == 0 ? $urandom_range(0, KeyBytes + 4) :
            $urandom_range(0, 3);
      send_cmd(m, len, pool,
               $urandom_range(0, 5) == 0 ? $urandom : code_pool[$urandom_range(0, 3)],
               $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
      if (n == 180) wait_drain();
    end
    wait_drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
